/* hw/rtl/lqm_pkg.sv */
// lqm_pkg: shared types and codes of the linked queue manager
// used by lqm_ctrl, lqm_dp, linked_queue_manager_top and the testbench files; no dependencies
package lqm_pkg;

  localparam int unsigned ID_W  = 6;
  localparam int unsigned LEN_W = 7;
  localparam int unsigned MAX_SLOTS = 1 << ID_W;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_LINKED = 2'd1;
  localparam logic [1:0] STAT_ABSENT = 2'd2;
  localparam logic [1:0] STAT_EMPTY  = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LINK2
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic link2;
    logic load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_link2;
  } dp_sts_t;

endpackage

/* hw/rtl/lqm_ram.sv */
// lqm_ram: generic single write port ram with registered read
// no dependencies
module lqm_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/lqm_ctrl.sv */
// lqm_ctrl: sequencing state machine and result valid of the queue manager
// depends on lqm_pkg
module lqm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  output logic             s_ready_o,
  output logic             m_valid_o,
  input  logic             m_ready_i,
  input  lqm_pkg::dp_sts_t sts_i,
  output lqm_pkg::dp_cmd_t cmd_o
);

  import lqm_pkg::*;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   out_free;

  assign out_free = !m_valid_q || m_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.need_link2) begin
          state_d = S_LINK2;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_LINK2: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o     = 1'b1;
        cmd_o.capture = s_valid_i;
      end
      S_EXEC: begin
        // first link write needs no free output slot
        cmd_o.exec = sts_i.need_link2 || out_free;
        cmd_o.load = !sts_i.need_link2 && out_free;
      end
      S_LINK2: begin
        cmd_o.link2 = out_free;
        cmd_o.load  = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (!m_valid_q || m_ready_i))
    else $error("result loaded over a pending transaction");

  a_link2_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK2) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_LINK2))
    else $error("second link step entered without first step");

  a_single_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> !cmd_o.capture)
    else $error("new transaction accepted while one is in flight");

endmodule

/* hw/rtl/lqm_dp.sv */
// lqm_dp: queue state, link rams, membership flags and result register
// depends on lqm_pkg and lqm_ram
module lqm_dp #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lqm_pkg::dp_cmd_t         cmd_i,
  output lqm_pkg::dp_sts_t         sts_o,
  input  logic [1:0]               cmd_code_i,
  input  logic [lqm_pkg::ID_W-1:0] elem_i,
  output logic [1:0]               status_o,
  output logic [lqm_pkg::ID_W-1:0] head_id_o,
  output logic                     is_empty_o,
  output logic [lqm_pkg::LEN_W-1:0] queue_len_o
);

  import lqm_pkg::*;

  // only slots reachable by a 6-bit slot number get storage
  localparam int unsigned DEPTH = (NUM_SLOTS < MAX_SLOTS) ? NUM_SLOTS : MAX_SLOTS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [12:0] NSLOTS = 13'(NUM_SLOTS);

  logic [1:0]       cmd_q;
  logic [ID_W-1:0]  elem_q;
  logic [ID_W-1:0]  head_q, head_d;
  logic [ID_W-1:0]  tail_q, tail_d;
  logic             empty_q, empty_d;
  logic [LEN_W-1:0] count_q, count_d;
  logic [DEPTH-1:0] member_q, member_d;

  logic [1:0]       out_status_q;
  logic [ID_W-1:0]  out_head_q;
  logic             out_empty_q;
  logic [LEN_W-1:0] out_len_q;

  logic [AW-1:0]    idx, raddr;
  logic             in_range, is_member;
  logic [1:0]       status_c;
  logic [ID_W-1:0]  next_rd, prev_rd;
  logic             next_we, prev_we;
  logic [AW-1:0]    next_waddr, prev_waddr;
  logic [ID_W-1:0]  next_wdata, prev_wdata;

  assign idx       = AW'(elem_q);
  assign raddr     = cmd_i.capture ? AW'(elem_i) : idx;
  assign in_range  = 13'(elem_q) < NSLOTS;
  assign is_member = in_range && member_q[idx];

  assign sts_o.need_link2 = (cmd_q == CMD_APPEND) && in_range && !is_member && !empty_q;

  lqm_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (next_we),
    .waddr_i(next_waddr),
    .wdata_i(next_wdata),
    .raddr_i(raddr),
    .rdata_o(next_rd)
  );

  lqm_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_prev_ram (
    .clk_i  (clk_i),
    .we_i   (prev_we),
    .waddr_i(prev_waddr),
    .wdata_i(prev_wdata),
    .raddr_i(raddr),
    .rdata_o(prev_rd)
  );

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    empty_d    = empty_q;
    count_d    = count_q;
    member_d   = member_q;
    status_c   = STAT_OK;
    next_we    = 1'b0;
    prev_we    = 1'b0;
    next_waddr = idx;
    prev_waddr = idx;
    next_wdata = elem_q;
    prev_wdata = elem_q;
    if (cmd_i.exec) begin
      case (cmd_q)
        CMD_APPEND: begin
          if (!in_range) begin
            status_c = STAT_ABSENT;
          end else if (is_member) begin
            status_c = STAT_LINKED;
          end else begin
            member_d[idx] = 1'b1;
            count_d       = count_q + 1'b1;
            tail_d        = elem_q;
            if (empty_q) begin
              // self loop
              next_we = 1'b1;
              prev_we = 1'b1;
              head_d  = elem_q;
              empty_d = 1'b0;
            end else begin
              next_we    = 1'b1;
              next_waddr = AW'(tail_q);
              prev_we    = 1'b1;
              prev_wdata = tail_q;
            end
          end
        end
        CMD_REMOVE: begin
          if (empty_q) begin
            status_c = STAT_EMPTY;
          end else if (!is_member) begin
            status_c = STAT_ABSENT;
          end else begin
            member_d[idx] = 1'b0;
            if (prev_rd == elem_q && next_rd == elem_q) begin
              empty_d = 1'b1;
              head_d  = '0;
              tail_d  = '0;
              count_d = '0;
            end else begin
              count_d    = count_q - 1'b1;
              next_we    = 1'b1;
              next_waddr = AW'(prev_rd);
              next_wdata = next_rd;
              prev_we    = 1'b1;
              prev_waddr = AW'(next_rd);
              prev_wdata = prev_rd;
              if (head_q == elem_q) begin
                head_d = next_rd;
              end
              if (tail_q == elem_q) begin
                tail_d = prev_rd;
              end
            end
          end
        end
        default: status_c = STAT_OK;
      endcase
    end else if (cmd_i.link2) begin
      // close the ring: new tail points back to the head
      next_we    = 1'b1;
      next_wdata = head_q;
      prev_we    = 1'b1;
      prev_waddr = AW'(head_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      empty_q  <= 1'b1;
      count_q  <= '0;
      member_q <= '0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      empty_q  <= empty_d;
      count_q  <= count_d;
      member_q <= member_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= cmd_code_i;
      elem_q <= elem_i;
    end
    if (cmd_i.load) begin
      out_status_q <= status_c;
      out_head_q   <= head_d;
      out_empty_q  <= empty_d;
      out_len_q    <= count_d;
    end
  end

  assign status_o    = out_status_q;
  assign head_id_o   = out_head_q;
  assign is_empty_o  = out_empty_q;
  assign queue_len_o = out_len_q;

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(member_q) == int'(count_q))
    else $error("element count differs from membership flags");

  a_empty_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q == (count_q == '0))
    else $error("empty flag differs from element count");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> (head_q == '0))
    else $error("head not cleared in empty queue");

endmodule

/* hw/rtl/linked_queue_manager_top.sv */
// Linked queue manager: one circular doubly linked queue over NUM_SLOTS slots.
// Each transaction is taken in S_IDLE (capture and link read), then updated in S_EXEC;
// an append to a non-empty queue adds S_LINK2 for its second write to each link ram.
// A new transaction is taken only once the last one has loaded its result;
// a result not yet taken by the receiver holds the next transaction in its update.
// Reset clears head, tail, count, empty and membership flags at once; link rams are not
// cleared and are only read for linked slots, so there is no clearing pass.
module linked_queue_manager_top #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [1:0] cmd, [7:2] elem_id
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [1:0] status, [7:2] head_id, [8] is_empty,
                                        // [15:9] queue_len
);

  import lqm_pkg::*;

  dp_cmd_t          dp_cmd;
  dp_sts_t          dp_sts;
  logic [1:0]       status;
  logic [ID_W-1:0]  head_id;
  logic             is_empty;
  logic [LEN_W-1:0] queue_len;

  lqm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid_i),
    .s_ready_o(s_axis_tready_o),
    .m_valid_o(m_axis_tvalid_o),
    .m_ready_i(m_axis_tready_i),
    .sts_i    (dp_sts),
    .cmd_o    (dp_cmd)
  );

  lqm_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .sts_o      (dp_sts),
    .cmd_code_i (s_axis_tdata_i[1:0]),
    .elem_i     (s_axis_tdata_i[7:2]),
    .status_o   (status),
    .head_id_o  (head_id),
    .is_empty_o (is_empty),
    .queue_len_o(queue_len)
  );

  assign m_axis_tdata_o = {queue_len, is_empty, head_id, status};

endmodule

/* tb/lqm_checker.sv */
`timescale 1ns / 100ps
// lqm_checker: watches both stream channels of linked_queue_manager_top, predicts
// every result from its own copy of the queue and compares; depends on lqm_pkg
module lqm_checker #(
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [1:0] cmd, [7:2] elem_id
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,   // [1:0] status, [7:2] head_id, [8] is_empty,
                                        // [15:9] queue_len
  output int          fail_cnt_o,
  output int          pending_o
);
  import lqm_pkg::*;

  typedef struct packed {
    logic [LEN_W-1:0] queue_len;
    logic             is_empty;
    logic [ID_W-1:0]  head_id;
    logic [1:0]       status;
  } queue_report_t;

  logic [ID_W-1:0]      succ [MAX_SLOTS];
  logic [ID_W-1:0]      pred [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] linked;
  logic [ID_W-1:0]      head_slot;
  logic                 q_empty;
  logic [LEN_W-1:0]     q_count;

  queue_report_t queue_reports [$];
  queue_report_t want;
  queue_report_t got;

  task automatic apply_queue_cmd(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                                 output queue_report_t rep);
    logic [1:0]      st;
    logic [ID_W-1:0] tail;
    logic [ID_W-1:0] p;
    logic [ID_W-1:0] n;
    st = STAT_OK;
    case (cmd)
      CMD_APPEND: begin
        if (int'(id) >= NUM_SLOTS) begin
          st = STAT_ABSENT;
        end else if (linked[id]) begin
          st = STAT_LINKED;
        end else begin
          if (q_empty) begin
            succ[id]  = id;
            pred[id]  = id;
            head_slot = id;
            q_empty   = 1'b0;
          end else begin
            // new element goes just before the head
            tail            = pred[head_slot];
            succ[tail]      = id;
            pred[id]        = tail;
            succ[id]        = head_slot;
            pred[head_slot] = id;
          end
          linked[id] = 1'b1;
          q_count    = q_count + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (q_empty) begin
          st = STAT_EMPTY;
        end else if (int'(id) >= NUM_SLOTS || !linked[id]) begin
          st = STAT_ABSENT;
        end else begin
          linked[id] = 1'b0;
          p = pred[id];
          n = succ[id];
          if (p == id && n == id) begin
            q_empty   = 1'b1;
            head_slot = '0;
            q_count   = '0;
          end else begin
            succ[p] = n;
            pred[n] = p;
            if (head_slot == id) head_slot = n;
            q_count = q_count - 1'b1;
          end
        end
      end
      default: ;  // query and the spare code change nothing
    endcase
    rep.status    = st;
    rep.head_id   = q_empty ? '0 : head_slot;
    rep.is_empty  = q_empty;
    rep.queue_len = q_count;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linked    = '0;
      head_slot = '0;
      q_empty   = 1'b1;
      q_count   = '0;
      queue_reports.delete();
      pending_o <= 0;
    end else begin
      // results first: nothing accepted at this edge can come out at the same edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = queue_report_t'(m_axis_tdata_i);
        if (queue_reports.size() == 0) begin
          $error("result transaction with nothing pending: %h", m_axis_tdata_i);
          fail_cnt_o++;
        end else begin
          want = queue_reports.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_cnt_o++;
          end
          if (got.head_id !== want.head_id) begin
            $error("head_id: expected %0d, got %0d", want.head_id, got.head_id);
            fail_cnt_o++;
          end
          if (got.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
            fail_cnt_o++;
          end
          if (got.queue_len !== want.queue_len) begin
            $error("queue_len: expected %0d, got %0d", want.queue_len, got.queue_len);
            fail_cnt_o++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        apply_queue_cmd(s_axis_tdata_i[1:0], s_axis_tdata_i[7:2], want);
        queue_reports.push_back(want);
      end
      pending_o <= queue_reports.size();
    end
  end

endmodule

/* tb/tb_linked_queue_manager_top.sv */
`timescale 1ns / 100ps
// tb_linked_queue_manager_top: command stimulus, result back-pressure and verdict
// for linked_queue_manager_top; checking is done by lqm_checker; depends on lqm_pkg
module tb_linked_queue_manager_top;
  import lqm_pkg::*;

  localparam int unsigned N_SLOTS    = 64;
  localparam int          RAND_ITEMS = 750;
  localparam int          LIMIT      = 500000;
  localparam logic [1:0]  CMD_SPARE  = 2'd3;  // unused code, behaves as a query

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  int fail_cnt;
  int pending;
  int items_sent = 0;
  int cycle_cnt = 0;
  bit no_idle = 1'b0;
  logic [N_SLOTS-1:0] slot_used = '0;  // steering only: which slots should be linked

  always #5 clk_i = ~clk_i;

  linked_queue_manager_top #(.NUM_SLOTS(N_SLOTS)) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  lqm_checker #(.NUM_SLOTS(N_SLOTS)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [5:0] pick_slot(input bit want_linked);
    int start;
    int k;
    logic [5:0] c;
    start = $urandom_range(0, N_SLOTS - 1);
    for (k = 0; k < N_SLOTS; k++) begin
      c = 6'((start + k) % N_SLOTS);
      if (slot_used[c] == want_linked) return c;
    end
    return start[5:0];
  endfunction

  task automatic send_cmd(input logic [1:0] cmd, input logic [5:0] id);
    int gap;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {id, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == CMD_APPEND) slot_used[id] = 1'b1;
    if (cmd == CMD_REMOVE) slot_used[id] = 1'b0;
    items_sent++;
  endtask

  // stop offering and wait until every result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // link every slot in random order, query, re-append one linked slot, then unlink them all in another order
  task automatic fill_and_empty();
    int order [N_SLOTS];
    int i;
    int j;
    int tmp;
    int pass;
    for (i = 0; i < N_SLOTS; i++) order[i] = i;
    for (pass = 0; pass < 2; pass++) begin
      for (i = N_SLOTS - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      for (i = 0; i < N_SLOTS; i++)
        send_cmd(pass == 0 ? CMD_APPEND : CMD_REMOVE, order[i][5:0]);
      if (pass == 0) begin
        send_cmd(CMD_QUERY, 6'd0);
        send_cmd(CMD_APPEND, order[$urandom_range(0, N_SLOTS - 1)][5:0]);
      end
    end
  endtask

  task automatic random_phase();
    int len;
    int bias;
    int n;
    int r;
    len  = $urandom_range(15, 60);
    bias = $urandom_range(20, 80);
    no_idle = ($urandom_range(0, 3) == 0);
    for (n = 0; n < len; n++) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        send_cmd(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)));
      else if (r < 15)
        send_cmd($urandom_range(0, 1) ? CMD_QUERY : CMD_SPARE, 6'($urandom_range(0, 63)));
      else if ($urandom_range(0, 99) < bias)
        send_cmd(CMD_APPEND, pick_slot(1'b0));
      else
        send_cmd(CMD_REMOVE, pick_slot(1'b1));
    end
    no_idle = 1'b0;
  endtask

  initial begin : stimulus
    int base;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(CMD_QUERY, 6'd0);
    send_cmd(CMD_REMOVE, 6'd5);      // empty queue
    send_cmd(CMD_SPARE, 6'd63);
    send_cmd(CMD_APPEND, 6'd0);
    send_cmd(CMD_APPEND, 6'd63);
    send_cmd(CMD_APPEND, 6'd0);      // already linked
    send_cmd(CMD_REMOVE, 6'd17);     // not a member
    send_cmd(CMD_APPEND, 6'd17);
    send_cmd(CMD_APPEND, 6'd42);
    send_cmd(CMD_QUERY, 6'd42);
    send_cmd(CMD_REMOVE, 6'd0);      // head leaves, successor takes over
    send_cmd(CMD_REMOVE, 6'd42);     // tail
    send_cmd(CMD_REMOVE, 6'd63);
    send_cmd(CMD_REMOVE, 6'd17);     // last element
    send_cmd(CMD_REMOVE, 6'd17);
    send_cmd(CMD_APPEND, 6'd21);
    send_cmd(CMD_REMOVE, 6'd21);
    send_cmd(CMD_APPEND, 6'd63);
    send_cmd(CMD_APPEND, 6'd42);
    send_cmd(CMD_APPEND, 6'd21);
    send_cmd(CMD_REMOVE, 6'd42);     // middle
    send_cmd(CMD_SPARE, 6'd0);
    drain();

    base = items_sent;
    fill_and_empty();
    while (items_sent < base + RAND_ITEMS) begin
      if ($urandom_range(0, 9) == 0)
        fill_and_empty();
      else
        random_phase();
      if ($urandom_range(0, 3) == 0) drain();
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin : sink
    int stall_left;
    int stall_pct;
    int span;
    bit long_done;
    stall_left = 0;
    stall_pct  = 25;
    span       = 0;
    long_done  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      // change how busy the receiver is now and then, zero gives idle-free stretches
      if (++span == 200) begin
        span = 0;
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 40);
      end
      if (!long_done && items_sent >= 300) begin
        long_done  = 1'b1;
        stall_left = 400;
      end else if (stall_left == 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/lqm_pkg.sv
hw/rtl/lqm_ram.sv
hw/rtl/lqm_ctrl.sv
hw/rtl/lqm_dp.sv
hw/rtl/linked_queue_manager_top.sv
tb/lqm_checker.sv
tb/tb_linked_queue_manager_top.sv
